// ===== sv/text_console_cursor_scroll_defines.svh =====
// Assertion macros for the text console engine.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

`ifndef SYNTH

// Property that must hold on every clock edge out of reset.
`define TCCS_CHECK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tccs check failed");

// Condition on one edge that forces a condition on the next edge.
`define TCCS_CHECK_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tccs sequence check failed");

`else

`define TCCS_CHECK(lbl, clk, rst_n, prop)
`define TCCS_CHECK_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

// ===== sv/tccs_pkg.sv =====
// Shared constants, types and helpers of the text console engine.
package tccs_pkg;

  localparam int COLUMNS       = 80;
  localparam int SCREEN_CELLS  = 2000;
  localparam int CONSOLES      = 3;
  localparam int CONSOLE_CELLS = 5461;

  // Port widths fixed by the interface.
  localparam int OW    = 14;
  localparam int CIDXW = 3;
  localparam int OPW   = 2;

  // Internal address width holds every sum formed against a slice end.
  localparam int AW  = $clog2(CONSOLES * CONSOLE_CELLS + SCREEN_CELLS + COLUMNS + 1);
  localparam int CIW = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
  localparam int CW  = $clog2(COLUMNS);

  // Request queue; depth must be a power of two so the pointers wrap.
  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd7;

  localparam logic [OPW-1:0] OP_PRINT  = 2'd0;
  localparam logic [OPW-1:0] OP_SCR_UP = 2'd1;
  localparam logic [OPW-1:0] OP_SCR_DN = 2'd2;
  localparam logic [OPW-1:0] OP_SELECT = 2'd3;

  localparam logic [2:0] K_NOP       = 3'd0;
  localparam logic [2:0] K_NEWLINE   = 3'd1;
  localparam logic [2:0] K_BACKSPACE = 3'd2;
  localparam logic [2:0] K_PUTC      = 3'd3;
  localparam logic [2:0] K_SCR_UP    = 3'd4;
  localparam logic [2:0] K_SCR_DN    = 3'd5;
  localparam logic [2:0] K_SELECT    = 3'd6;

  typedef struct packed {
    logic [2:0]     kind;
    logic [CIW-1:0] console;
    logic [7:0]     character;
  } cmd_t;

  typedef struct packed {
    logic             cell_write;
    logic [OW-1:0]    cell_address;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic [OW-1:0]    crtc_cursor;
    logic [OW-1:0]    crtc_start;
    logic [CIDXW-1:0] active_console;
  } res_t;

  function automatic logic [AW-1:0] base_of(logic [CIW-1:0] c);
    return AW'(c) * AW'(CONSOLE_CELLS);
  endfunction

endpackage

// ===== sv/tccs_front.sv =====
// Front end: takes requests and sorts them into execution commands.
module tccs_front (
  input  logic                         start,
  output logic                         busy,
  input  logic [tccs_pkg::OPW-1:0]     in_op,
  input  logic [tccs_pkg::CIDXW-1:0]   in_console_index,
  input  logic [7:0]                   in_character,
  input  logic                         q_full,
  output logic                         q_push,
  output tccs_pkg::cmd_t               q_cmd
);
  import tccs_pkg::*;

  logic cons_ok;

  assign busy    = q_full;
  assign q_push  = start && !q_full;
  assign cons_ok = {1'b0, in_console_index} < (CIDXW + 1)'(CONSOLES);

  always_comb begin
    q_cmd.character = in_character;
    q_cmd.console   = cons_ok ? CIW'(in_console_index) : '0;
    q_cmd.kind      = K_NOP;
    if (cons_ok) begin
      unique case (in_op)
        OP_PRINT: begin
          if (in_character == CH_NEWLINE) begin
            q_cmd.kind = K_NEWLINE;
          end else if (in_character == CH_BACKSPACE) begin
            q_cmd.kind = K_BACKSPACE;
          end else begin
            q_cmd.kind = K_PUTC;
          end
        end
        OP_SCR_UP: q_cmd.kind = K_SCR_UP;
        OP_SCR_DN: q_cmd.kind = K_SCR_DN;
        OP_SELECT: q_cmd.kind = K_SELECT;
        default:   q_cmd.kind = K_NOP;
      endcase
    end
  end

endmodule

// ===== sv/tccs_queue.sv =====
// Short command queue between the front end and the execution unit.
module tccs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tccs_pkg::cmd_t din,
  input  logic           pop,
  output tccs_pkg::cmd_t dout,
  output logic           empty,
  output logic           full
);
  import tccs_pkg::*;

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == QCW'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== sv/tccs_back.sv =====
// Execution unit: console state, cursor and scroll updates, result register.
module tccs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  tccs_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_data,
  output logic           res_valid,
  output tccs_pkg::res_t res
);
  import tccs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [AW-1:0]    cur_arr_r [CONSOLES];
  logic [AW-1:0]    vs_arr_r  [CONSOLES];
  logic [CW-1:0]    col_arr_r [CONSOLES];
  logic [CIDXW-1:0] sel_r;
  logic [OW-1:0]    hw_cursor_r, hw_start_r;
  logic [7:0]       attr_r;
  logic             res_valid_r;
  res_t             res_r;

  // Working registers of the command in flight.
  cmd_t             cmd_r;
  logic [AW-1:0]    cur_r, vs_r, end_r, waddr_r;
  logic [CW-1:0]    col_r;
  logic             wr_r, loop_r;
  logic [7:0]       wchar_r;

  logic [CIW-1:0]   idx;
  logic [AW-1:0]    cur, vs, base, endc;
  logic [CW-1:0]    col;
  logic [AW-1:0]    cur_x, vs_x, waddr_x;
  logic [CW-1:0]    col_x;
  logic             wr_x;
  logic [7:0]       wchar_x;
  logic [AW-1:0]    lim;
  logic             more, is_op;
  logic [OW-1:0]    hw_cur_f, hw_st_f;
  logic [CIDXW-1:0] sel_f;

  assign cmd_pop = (state_r == S_IDLE) && cmd_valid;

  always_comb begin
    idx     = cmd_r.console;
    cur     = cur_arr_r[idx];
    vs      = vs_arr_r[idx];
    col     = col_arr_r[idx];
    base    = base_of(idx);
    endc    = base + AW'(CONSOLE_CELLS);
    cur_x   = cur;
    vs_x    = vs;
    col_x   = col;
    wr_x    = 1'b0;
    waddr_x = '0;
    wchar_x = '0;
    unique case (cmd_r.kind)
      K_NEWLINE: begin
        // The column count gives the distance to the next line start.
        if (cur + AW'(COLUMNS) < endc) begin
          cur_x = cur + AW'(COLUMNS) - AW'(col);
          col_x = '0;
        end
      end
      K_BACKSPACE: begin
        if (cur > base) begin
          cur_x   = cur - 1'b1;
          col_x   = (col == '0) ? CW'(COLUMNS - 1) : col - 1'b1;
          wr_x    = 1'b1;
          waddr_x = cur - 1'b1;
          wchar_x = CH_SPACE;
        end
      end
      K_PUTC: begin
        if (cur + 1'b1 < endc) begin
          cur_x   = cur + 1'b1;
          col_x   = (col == CW'(COLUMNS - 1)) ? '0 : col + 1'b1;
          wr_x    = 1'b1;
          waddr_x = cur;
          wchar_x = cmd_r.character;
        end
      end
      K_SCR_UP: begin
        if (vs > base) begin
          vs_x = vs - AW'(COLUMNS);
        end
      end
      K_SCR_DN: begin
        if (vs + AW'(SCREEN_CELLS) < endc) begin
          vs_x = vs + AW'(COLUMNS);
        end
      end
      default: ;
    endcase
  end

  // After a print the view follows the cursor one line per cycle.
  always_comb begin
    lim      = vs_r + AW'(SCREEN_CELLS);
    more     = loop_r && (cur_r >= lim) && (lim < end_r);
    is_op    = (cmd_r.kind != K_NOP);
    hw_cur_f = is_op ? OW'(cur_r) : hw_cursor_r;
    hw_st_f  = is_op ? OW'(vs_r) : hw_start_r;
    sel_f    = (cmd_r.kind == K_SELECT) ? CIDXW'(cmd_r.console) : sel_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (cmd_valid) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_FIN;
      S_FIN:   if (!more) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= '0;
      hw_cursor_r <= '0;
      hw_start_r  <= '0;
      attr_r      <= ATTR_RESET;
      res_valid_r <= 1'b0;
      for (int i = 0; i < CONSOLES; i++) begin
        cur_arr_r[i] <= base_of(CIW'(i));
        vs_arr_r[i]  <= base_of(CIW'(i));
        col_arr_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= (state_r == S_FIN) && !more;
      if (cfg_we) begin
        attr_r <= cfg_data;
      end
      if (state_r == S_FIN && !more && is_op) begin
        cur_arr_r[cmd_r.console] <= cur_r;
        vs_arr_r[cmd_r.console]  <= vs_r;
        col_arr_r[cmd_r.console] <= col_r;
        hw_cursor_r              <= hw_cur_f;
        hw_start_r               <= hw_st_f;
        sel_r                    <= sel_f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd;
    end
    if (state_r == S_EXEC) begin
      cur_r   <= cur_x;
      vs_r    <= vs_x;
      col_r   <= col_x;
      end_r   <= endc;
      wr_r    <= wr_x;
      waddr_r <= waddr_x;
      wchar_r <= wchar_x;
      loop_r  <= (cmd_r.kind == K_NEWLINE) || (cmd_r.kind == K_BACKSPACE) ||
                 (cmd_r.kind == K_PUTC);
    end else if (state_r == S_FIN && more) begin
      vs_r <= vs_r + AW'(COLUMNS);
    end
    if (state_r == S_FIN && !more) begin
      res_r.cell_write     <= wr_r;
      res_r.cell_address   <= OW'(waddr_r);
      res_r.cell_char      <= wchar_r;
      res_r.cell_attr      <= wr_r ? attr_r : 8'd0;
      res_r.crtc_cursor    <= hw_cur_f;
      res_r.crtc_start     <= hw_st_f;
      res_r.active_console <= sel_f;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== sv/text_console_cursor_scroll.sv =====
// Top level of the multi-console text engine: front end, queue and execution unit.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  request  | start / busy         | in_op, in_console_index, in_character
//  result   | out_valid (strobe)   | out_cell_*, out_crtc_*, out_active_console
//  config   | cfg_we               | cfg_data (text attribute)
//
// A request passes the execution unit's idle, execute and finish states and then the
// result register; a print stays in the finish state for each line the view scrolls
// to follow the cursor, as the single-step scroll loop moves the view a line at a time.
// The front end takes up to two requests ahead while the execution unit works.
// Reset is synchronous and active low; results cannot be stalled.
module text_console_cursor_scroll (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [tccs_pkg::OPW-1:0]   in_op,
  input  logic [tccs_pkg::CIDXW-1:0] in_console_index,
  input  logic [7:0]                 in_character,
  input  logic                       cfg_we,
  input  logic [7:0]                 cfg_data,
  output logic                       out_valid,
  output logic                       out_cell_write,
  output logic [tccs_pkg::OW-1:0]    out_cell_address,
  output logic [7:0]                 out_cell_char,
  output logic [7:0]                 out_cell_attr,
  output logic [tccs_pkg::OW-1:0]    out_crtc_cursor,
  output logic [tccs_pkg::OW-1:0]    out_crtc_start,
  output logic [tccs_pkg::CIDXW-1:0] out_active_console
);
  import tccs_pkg::*;

  `include "text_console_cursor_scroll_defines.svh"

  logic q_push, q_full, q_empty, q_pop;
  cmd_t q_in, q_out;
  res_t res;

  tccs_front u_front (
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_console_index (in_console_index),
    .in_character     (in_character),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_in)
  );

  tccs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty),
    .full  (q_full)
  );

  tccs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (q_out),
    .cmd_pop   (q_pop),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_cell_write     = res.cell_write;
  assign out_cell_address   = res.cell_address;
  assign out_cell_char      = res.cell_char;
  assign out_cell_attr      = res.cell_attr;
  assign out_crtc_cursor    = res.crtc_cursor;
  assign out_crtc_start     = res.crtc_start;
  assign out_active_console = res.active_console;

  // Each request passes the execute and finish states, so strobes never touch.
  `TCCS_CHECK_NEXT(a_strobe_gap, clk, rst_n, out_valid, !out_valid)
  // A result without a cell write carries zeroed cell fields.
  `TCCS_CHECK(a_no_write_zero, clk, rst_n,
    !(out_valid && !out_cell_write) ||
    (out_cell_address == '0 && out_cell_char == 8'd0 && out_cell_attr == 8'd0))
  // Selects beyond the console count never reach the active console.
  `TCCS_CHECK(a_active_range, clk, rst_n,
    !out_valid || ({1'b0, out_active_console} < (CIDXW + 1)'(CONSOLES)))
  // A full queue always holds the front end off.
  `TCCS_CHECK(a_full_busy, clk, rst_n, !q_full || busy)

endmodule
